// ===== src/qare_pkg.sv =====
// ----------------------------------------------------------------------------
// qare_pkg
// Shared types and constants of the quaternion angular-rate estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package qare_pkg;

   // Frame counter and stencil geometry.
   localparam int FRAME_INDEX_BITS   = 16;
   localparam int STENCIL_HALF_WIDTH = 2;
   localparam int WIN                = 2 * STENCIL_HALF_WIDTH + 1;
   localparam int CENTER_TAP         = STENCIL_HALF_WIDTH;
   localparam int COMP_N             = 4;

   // Fixed-point widths.
   localparam int QUAT_W = 16;
   localparam int RATE_W = 32;
   localparam int QDD_W  = 44;
   localparam int OUT_W  = 32;
   localparam int CSR_W  = 16;

   // Shared multiply-accumulate unit.
   localparam int MAC_A_W    = 44;
   localparam int MAC_B_W    = 21;
   localparam int MAC_PROD_W = MAC_A_W + MAC_B_W;
   localparam int ACC_W      = 64;

   localparam logic [CSR_W-1:0] RATE_OVER_TWELVE_RESET = 16'd2560;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic                     last_frame;
   } req_payload_type;

   typedef struct packed {
      logic [FRAME_INDEX_BITS-1:0] frame_index;
      logic signed [OUT_W-1:0]     ang_vel_x;
      logic signed [OUT_W-1:0]     ang_vel_y;
      logic signed [OUT_W-1:0]     ang_vel_z;
      logic signed [OUT_W-1:0]     ang_acc_x;
      logic signed [OUT_W-1:0]     ang_acc_y;
      logic signed [OUT_W-1:0]     ang_acc_z;
      logic                        last_result;
   } rsp_payload_type;

   // Control that travels with one product through the MAC unit.
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [1:0] tag;
   } mac_op_type;

   // Completion of one four-term sum.
   typedef struct packed {
      logic       valid;
      logic [1:0] tag;
   } mac_done_type;

endpackage

`default_nettype wire

// ===== src/qare_mac.sv =====
// ----------------------------------------------------------------------------
// qare_mac
// Shared two-stage multiply-accumulate unit: a registered product, then a
// registered accumulator that restarts on the first term of each sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qare_mac
   import qare_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mac_op_type                op,
   input  wire logic signed [MAC_A_W-1:0] op_a,
   input  wire logic signed [MAC_B_W-1:0] op_b,
   output mac_done_type                   done,
   output logic signed [ACC_W-1:0]        sum
);

   logic signed [MAC_PROD_W-1:0] prod_full;
   logic signed [ACC_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]      prod_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   mac_op_type                   p_ctl_ff;
   mac_done_type                 done_ff;

   // Full product; every sum used here stays well inside the accumulator.
   assign prod_full = MAC_PROD_W'(op_a) * MAC_PROD_W'(op_b);
   assign prod_in   = prod_full[ACC_W-1:0];
   assign acc_in    = p_ctl_ff.first ? prod_ff : acc_ff + prod_ff;

   // Control pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff <= '0;
         done_ff  <= '0;
      end else begin
         p_ctl_ff      <= op;
         done_ff.valid <= p_ctl_ff.valid && p_ctl_ff.last;
         done_ff.tag   <= p_ctl_ff.tag;
      end
   end

   // Data pipeline.
   always_ff @(posedge clock) begin
      if (op.valid) begin
         prod_ff <= prod_in;
      end
      if (p_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

`default_nettype wire

// ===== src/quaternion_angular_rate_estimator_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_angular_rate_estimator_top
// Angular velocity and acceleration of one joint from a quaternion track.
// ----------------------------------------------------------------------------
// Once the window is full, each frame takes five passes over the single
// multiply-accumulate unit (sign dot products, quaternion rate, second
// difference, velocity and acceleration) at one product per cycle, each
// followed by the pipeline drain, plus the step decode, the rate push, the
// output load and the finish. The first two frames of a track only fill the
// quaternion window, and the third and fourth also compute rates that fill
// the rate window. A frame flagged last adds four flush steps (the last two
// only repeat the last rate), giving the remaining results, up to four.
// Results lag their frame by four frames, and the block takes no new frame
// until the current one, including its flush, is finished; a finished result
// waits in the output register without holding up the next frame, but the
// following result stalls until that register is free.
`default_nettype none

module quaternion_angular_rate_estimator_top
   import qare_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   localparam int NK_W = FRAME_INDEX_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_STEP, S_DOT, S_RATE, S_RPUSH, S_QDD, S_VEL, S_ACC, S_OUT, S_FIN
   } state_type;

   state_type                   state_ff;
   logic [CSR_W-1:0]            rate_cfg_ff;
   logic [FRAME_INDEX_BITS-1:0] frames_seen_ff;
   logic [FRAME_INDEX_BITS-1:0] emit_index_ff;
   logic [FRAME_INDEX_BITS-1:0] n_ff;
   logic [2:0]                  k_ff;
   logic                        last_ff;
   logic [1:0]                  comp_ff;
   logic [1:0]                  term_ff;
   logic                        issue_done_ff;
   logic                        rsp_valid_ff;

   logic signed [QUAT_W-1:0] qwin_ff   [WIN][COMP_N];
   logic signed [RATE_W-1:0] rwin_ff   [WIN][COMP_N];
   logic signed [RATE_W-1:0] rnew_ff   [COMP_N];
   logic signed [QDD_W-1:0]  qdd_ff    [COMP_N];
   logic signed [OUT_W-1:0]  vel_ff    [3];
   logic signed [OUT_W-1:0]  accel_ff  [3];
   logic                     neg_ff    [COMP_N];
   rsp_payload_type          rsp_payload_ff;

   logic signed [QUAT_W-1:0] qin [COMP_N];
   logic [NK_W-1:0]          nk;
   logic                     accept;
   logic                     mac_phase;
   logic                     mac_issue;
   logic [1:0]               last_comp;
   logic                     sum_last;
   logic                     out_load;
   logic                     step_shift_q;
   logic                     step_hold_r;

   mac_op_type                mac_op;
   mac_done_type              mac_done;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   mac_sum;

   logic signed [ACC_W-1:0]  sum_r6;
   logic signed [ACC_W-1:0]  sum_r8;
   logic signed [ACC_W-1:0]  sum_r13;
   logic signed [OUT_W-1:0]  sum_sat;

   // Stencil slot to window tap: slots skip the center, whose weight is zero.
   function automatic logic [2:0] slot_tap(input logic [1:0] s);
      case (s)
         2'd0:    slot_tap = 3'd0;
         2'd1:    slot_tap = 3'd1;
         2'd2:    slot_tap = 3'd3;
         default: slot_tap = 3'd4;
      endcase
   endfunction

   // Weight of a slot times the rate register: +1, -8, +8, -1.
   function automatic logic signed [MAC_B_W-1:0] slot_weight(
      input logic [1:0] s, input logic flip, input logic [CSR_W-1:0] r);
      logic signed [MAC_B_W-1:0] w;
      w = (s[0] ^ s[1]) ? $signed(MAC_B_W'({r, 3'b000})) : $signed(MAC_B_W'(r));
      slot_weight = (s[0] ^ flip) ? -w : w;
   endfunction

   // Coefficient of the vector part of conj(q) * d: returns {negate, q index}.
   function automatic logic [2:0] body_coef(input logic [1:0] axis,
                                            input logic [1:0] t);
      logic [3:0] sel;
      sel = {axis, t};
      case (sel)
         4'b00_00: body_coef = {1'b1, 2'd1};
         4'b00_01: body_coef = {1'b0, 2'd0};
         4'b00_10: body_coef = {1'b0, 2'd3};
         4'b00_11: body_coef = {1'b1, 2'd2};
         4'b01_00: body_coef = {1'b1, 2'd2};
         4'b01_01: body_coef = {1'b1, 2'd3};
         4'b01_10: body_coef = {1'b0, 2'd0};
         4'b01_11: body_coef = {1'b0, 2'd1};
         4'b10_00: body_coef = {1'b1, 2'd3};
         4'b10_01: body_coef = {1'b0, 2'd2};
         4'b10_10: body_coef = {1'b1, 2'd1};
         default:  body_coef = {1'b0, 2'd0};
      endcase
   endfunction

   assign qin[0] = req_payload.quat_w;
   assign qin[1] = req_payload.quat_x;
   assign qin[2] = req_payload.quat_y;
   assign qin[3] = req_payload.quat_z;

   // Handshake and step decode.
   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign nk           = NK_W'(n_ff) + NK_W'(k_ff);
   assign mac_phase    = (state_ff == S_DOT) || (state_ff == S_RATE) ||
                         (state_ff == S_QDD) || (state_ff == S_VEL) ||
                         (state_ff == S_ACC);
   assign mac_issue    = mac_phase && !issue_done_ff;
   assign last_comp    = ((state_ff == S_VEL) || (state_ff == S_ACC)) ? 2'd2 : 2'd3;
   assign sum_last     = mac_done.valid && (mac_done.tag == last_comp);
   assign out_load     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign step_shift_q = (state_ff == S_STEP) && (k_ff != 3'd0);
   assign step_hold_r  = (state_ff == S_STEP) && (k_ff >= 3'd3);

   // Operand selection for the shared MAC.
   always_comb begin
      logic [2:0] coef;
      coef          = body_coef(comp_ff, term_ff);
      mac_op.valid  = mac_issue;
      mac_op.first  = (term_ff == 2'd0);
      mac_op.last   = (term_ff == 2'd3);
      mac_op.tag    = comp_ff;
      mac_a         = '0;
      mac_b         = '0;
      unique case (state_ff)
         S_DOT: begin
            mac_a = MAC_A_W'(qwin_ff[slot_tap(comp_ff)][term_ff]);
            mac_b = MAC_B_W'(qwin_ff[CENTER_TAP][term_ff]);
         end
         S_RATE: begin
            mac_a = MAC_A_W'(qwin_ff[slot_tap(term_ff)][comp_ff]);
            mac_b = slot_weight(term_ff, neg_ff[term_ff], rate_cfg_ff);
         end
         S_QDD: begin
            mac_a = MAC_A_W'(rwin_ff[slot_tap(term_ff)][comp_ff]);
            mac_b = slot_weight(term_ff, 1'b0, rate_cfg_ff);
         end
         S_VEL: begin
            mac_a = MAC_A_W'(rwin_ff[CENTER_TAP][term_ff]);
            mac_b = coef[2] ? -MAC_B_W'(qwin_ff[0][coef[1:0]])
                            :  MAC_B_W'(qwin_ff[0][coef[1:0]]);
         end
         S_ACC: begin
            mac_a = MAC_A_W'(qdd_ff[term_ff]);
            mac_b = coef[2] ? -MAC_B_W'(qwin_ff[0][coef[1:0]])
                            :  MAC_B_W'(qwin_ff[0][coef[1:0]]);
         end
         default: begin
            mac_a = '0;
            mac_b = '0;
         end
      endcase
   end

   qare_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .done  (mac_done),
      .sum   (mac_sum)
   );

   // Rounding half up by arithmetic shift; the 13-bit shift is then saturated to 32 bits.
   assign sum_r6  = (mac_sum + 64'sd32) >>> 6;
   assign sum_r8  = (mac_sum + 64'sd128) >>> 8;
   assign sum_r13 = (mac_sum + 64'sd4096) >>> 13;
   assign sum_sat = (sum_r13 > 64'sd2147483647)  ? 32'sh7fffffff :
                    (sum_r13 < -64'sd2147483648) ? 32'sh80000000 :
                    sum_r13[OUT_W-1:0];

   // Sequencer and track counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rate_cfg_ff    <= RATE_OVER_TWELVE_RESET;
         frames_seen_ff <= '0;
         emit_index_ff  <= '0;
         n_ff           <= '0;
         k_ff           <= '0;
         last_ff        <= 1'b0;
         comp_ff        <= '0;
         term_ff        <= '0;
         issue_done_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rate_cfg_ff <= csr_wr_data;
         end
         // A taken result clears the output unless a new one loads now.
         if (rsp_valid_ff && rsp_ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mac_issue) begin
            term_ff <= term_ff + 2'd1;
            if (term_ff == 2'd3) begin
               comp_ff <= comp_ff + 2'd1;
               if (comp_ff == last_comp) begin
                  issue_done_ff <= 1'b1;
               end
            end
         end
         if (sum_last) begin
            issue_done_ff <= 1'b0;
            comp_ff       <= '0;
            term_ff       <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  n_ff    <= frames_seen_ff;
                  k_ff    <= '0;
                  last_ff <= req_payload.last_frame;
                  if (frames_seen_ff != '1) begin
                     frames_seen_ff <= frames_seen_ff + 1'b1;
                  end
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if ((k_ff <= 3'd2) && (nk >= NK_W'(2))) begin
                  state_ff <= S_DOT;
               end else if (nk >= NK_W'(4)) begin
                  state_ff <= S_QDD;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_DOT: if (sum_last) state_ff <= S_RATE;
            S_RATE: if (sum_last) state_ff <= S_RPUSH;
            S_RPUSH: begin
               state_ff <= (nk >= NK_W'(4)) ? S_QDD : S_FIN;
            end
            S_QDD: if (sum_last) state_ff <= S_VEL;
            S_VEL: if (sum_last) state_ff <= S_ACC;
            S_ACC: if (sum_last) state_ff <= S_OUT;
            S_OUT: begin
               if (out_load) begin
                  rsp_valid_ff  <= 1'b1;
                  emit_index_ff <= emit_index_ff + 1'b1;
                  state_ff      <= S_FIN;
               end
            end
            S_FIN: begin
               if (last_ff && (k_ff != 3'd4)) begin
                  k_ff     <= k_ff + 3'd1;
                  state_ff <= S_STEP;
               end else begin
                  if (last_ff) begin
                     frames_seen_ff <= '0;
                     emit_index_ff  <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Windows, intermediate sums and the result register.
   always_ff @(posedge clock) begin
      // Quaternion window: fill on a new track, shift on each frame or flush.
      if (accept) begin
         for (int i = 0; i < WIN; i++) begin
            for (int c = 0; c < COMP_N; c++) begin
               if (frames_seen_ff == '0) begin
                  qwin_ff[i][c] <= qin[c];
               end else if (i == WIN - 1) begin
                  qwin_ff[i][c] <= qin[c];
               end else begin
                  qwin_ff[i][c] <= qwin_ff[i+1][c];
               end
            end
         end
      end else if (step_shift_q) begin
         for (int i = 0; i < WIN - 1; i++) begin
            for (int c = 0; c < COMP_N; c++) begin
               qwin_ff[i][c] <= qwin_ff[i+1][c];
            end
         end
      end

      // Rate window: fill with the first rate, shift new or repeated rates.
      if (state_ff == S_RPUSH) begin
         for (int i = 0; i < WIN; i++) begin
            for (int c = 0; c < COMP_N; c++) begin
               if ((nk == NK_W'(2)) || (i == WIN - 1)) begin
                  rwin_ff[i][c] <= rnew_ff[c];
               end else begin
                  rwin_ff[i][c] <= rwin_ff[i+1][c];
               end
            end
         end
      end else if (step_hold_r) begin
         for (int i = 0; i < WIN - 1; i++) begin
            for (int c = 0; c < COMP_N; c++) begin
               rwin_ff[i][c] <= rwin_ff[i+1][c];
            end
         end
      end

      // Write back each finished four-term sum.
      if (mac_done.valid) begin
         case (state_ff)
            S_DOT:   neg_ff[mac_done.tag]   <= mac_sum[ACC_W-1];
            S_RATE:  rnew_ff[mac_done.tag]  <= sum_r6[RATE_W-1:0];
            S_QDD:   qdd_ff[mac_done.tag]   <= sum_r8[QDD_W-1:0];
            S_VEL:   vel_ff[mac_done.tag]   <= sum_sat;
            S_ACC:   accel_ff[mac_done.tag] <= sum_sat;
            default: ;
         endcase
      end

      if (out_load) begin
         rsp_payload_ff.frame_index <= emit_index_ff;
         rsp_payload_ff.ang_vel_x   <= vel_ff[0];
         rsp_payload_ff.ang_vel_y   <= vel_ff[1];
         rsp_payload_ff.ang_vel_z   <= vel_ff[2];
         rsp_payload_ff.ang_acc_x   <= accel_ff[0];
         rsp_payload_ff.ang_acc_y   <= accel_ff[1];
         rsp_payload_ff.ang_acc_z   <= accel_ff[2];
         rsp_payload_ff.last_result <= last_ff && (k_ff == 3'd4);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The MAC is never busy while a new frame can be taken.
   a_idle_no_issue: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mac_op.valid)
      else $error("MAC issued a product while the block was ready");

   // No sum completes after the sequencer has gone back to idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mac_done.valid)
      else $error("MAC result arrived with the sequencer idle");

   // A new result only comes from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("Result loaded outside the output state");

   // Flush steps happen only on a track's last frame.
   a_flush_on_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_STEP) && (k_ff != 3'd0)) |-> last_ff)
      else $error("Flush step without a last frame");

endmodule

`default_nettype wire

// ===== sim/quaternion_angular_rate_estimator_top_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_angular_rate_estimator_top_tb
// Self-checking bench for the quaternion angular-rate estimator. Tracks of
// quaternion frames are driven over the request channel, an in-bench
// predictor computes the expected velocity and acceleration for every
// frame, and the monitor compares each response transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_angular_rate_estimator_top_tb
   import qare_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLUSH_WAIT = 500;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   quaternion_angular_rate_estimator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: quaternion and rate windows, counters and the scale.
   typedef logic signed [63:0] s64_type;
   s64_type         quat_hist [WIN][COMP_N];
   s64_type         rate_hist [WIN][COMP_N];
   int unsigned     track_frames;
   int unsigned     next_emit;
   logic [CSR_W-1:0] scale_reg;

   req_payload_type frame_queue [$];
   rsp_payload_type expected_results [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int errors;
   int frames_sent;
   int results_seen;
   int tracks_sent;
   bit stimulus_done;

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Rounding shift, half toward plus infinity.
   function automatic s64_type round_sh(input s64_type v, input int s);
      s64_type t;
      t = v + (s64_type'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic s64_type clamp32(input s64_type v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic s64_type tap_weight(input int j);
      case (j)
         0: return 1;
         1: return -8;
         3: return 8;
         4: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic shift_quat(input s64_type q [COMP_N]);
      for (int i = 0; i < WIN - 1; i++)
         for (int k = 0; k < COMP_N; k++) quat_hist[i][k] = quat_hist[i+1][k];
      for (int k = 0; k < COMP_N; k++) quat_hist[WIN-1][k] = q[k];
   endtask

   task automatic shift_rate(input s64_type r [COMP_N], input bit fill);
      for (int i = 0; i < WIN - 1; i++)
         for (int k = 0; k < COMP_N; k++)
            rate_hist[i][k] = fill ? r[k] : rate_hist[i+1][k];
      for (int k = 0; k < COMP_N; k++) rate_hist[WIN-1][k] = r[k];
   endtask

   // Quaternion rate of the window center, with hemisphere alignment.
   task automatic center_rate(output s64_type r [COMP_N]);
      s64_type sum [COMP_N];
      s64_type dot;
      for (int k = 0; k < COMP_N; k++) sum[k] = 0;
      for (int j = 0; j < WIN; j++) begin
         dot = 0;
         for (int k = 0; k < COMP_N; k++) dot += quat_hist[2][k] * quat_hist[j][k];
         for (int k = 0; k < COMP_N; k++)
            sum[k] += (dot < 0) ? -tap_weight(j) * quat_hist[j][k]
                                : tap_weight(j) * quat_hist[j][k];
      end
      for (int k = 0; k < COMP_N; k++)
         r[k] = round_sh(sum[k] * s64_type'({48'd0, scale_reg}), 6);
   endtask

   // Vector part of 2*conj(q)*d in Q16.16.
   task automatic body_rate(input s64_type d [COMP_N],
                            output logic signed [31:0] v [3]);
      s64_type w, x, y, z;
      w = quat_hist[0][0]; x = quat_hist[0][1]; y = quat_hist[0][2]; z = quat_hist[0][3];
      v[0] = 32'(clamp32(round_sh(-x*d[0] + w*d[1] + z*d[2] - y*d[3], 13)));
      v[1] = 32'(clamp32(round_sh(-y*d[0] - z*d[1] + w*d[2] + x*d[3], 13)));
      v[2] = 32'(clamp32(round_sh(-z*d[0] + y*d[1] - x*d[2] + w*d[3], 13)));
   endtask

   task automatic add_expected(input bit is_last);
      rsp_payload_type res;
      s64_type d [COMP_N];
      s64_type t;
      logic signed [31:0] v [3];
      for (int k = 0; k < COMP_N; k++) d[k] = rate_hist[2][k];
      body_rate(d, v);
      res.ang_vel_x = v[0]; res.ang_vel_y = v[1]; res.ang_vel_z = v[2];
      for (int k = 0; k < COMP_N; k++) begin
         t = 0;
         for (int j = 0; j < WIN; j++) t += tap_weight(j) * rate_hist[j][k];
         d[k] = round_sh(t * s64_type'({48'd0, scale_reg}), 8);
      end
      body_rate(d, v);
      res.ang_acc_x = v[0]; res.ang_acc_y = v[1]; res.ang_acc_z = v[2];
      res.frame_index = next_emit[FRAME_INDEX_BITS-1:0];
      res.last_result = is_last;
      expected_results = {expected_results, res};
      next_emit = (next_emit + 1) & ((1 << FRAME_INDEX_BITS) - 1);
   endtask

   // Advance the predictor by one accepted frame.
   task automatic predict_frame(input req_payload_type f);
      s64_type q [COMP_N];
      s64_type r [COMP_N];
      int unsigned n;
      n = track_frames;
      q[0] = 64'(f.quat_w); q[1] = 64'(f.quat_x);
      q[2] = 64'(f.quat_y); q[3] = 64'(f.quat_z);
      if (n == 0)
         for (int i = 0; i < WIN; i++) shift_quat(q);
      else
         shift_quat(q);
      if (n >= 2) begin
         center_rate(r);
         shift_rate(r, n == 2);
      end
      if (n >= 4) add_expected(1'b0);
      if (n < (1 << FRAME_INDEX_BITS) - 1) track_frames = n + 1;
      if (f.last_frame) begin
         for (int k = 1; k <= 4; k++) begin
            for (int c = 0; c < COMP_N; c++) q[c] = quat_hist[WIN-1][c];
            shift_quat(q);
            if (k <= 2) begin
               if (n + k >= 2) begin
                  center_rate(r);
                  shift_rate(r, n + k == 2);
               end
            end else begin
               for (int c = 0; c < COMP_N; c++) r[c] = rate_hist[WIN-1][c];
               shift_rate(r, 1'b0);
            end
            if (n + k >= 4) add_expected(k == 4);
         end
         track_frames = 0;
         next_emit = 0;
      end
   endtask

   // Random quaternion near a running rotation, sometimes arbitrary.
   function automatic req_payload_type rand_frame(input bit is_last);
      req_payload_type f;
      if ($urandom_range(0, 9) == 0) begin
         f.quat_w = 16'($urandom); f.quat_x = 16'($urandom);
         f.quat_y = 16'($urandom); f.quat_z = 16'($urandom);
      end else begin
         f.quat_w = 16'sd12000 + $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
         f.quat_x = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
         f.quat_y = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
         f.quat_z = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
         if ($urandom_range(0, 3) == 0) begin
            f.quat_w = -f.quat_w; f.quat_x = -f.quat_x;
            f.quat_y = -f.quat_y; f.quat_z = -f.quat_z;
         end
      end
      f.last_frame = is_last;
      return f;
   endfunction

   function automatic req_payload_type mk_frame(input int w, x, y, z, input bit is_last);
      req_payload_type f;
      f.quat_w = 16'(w); f.quat_x = 16'(x); f.quat_y = 16'(y); f.quat_z = 16'(z);
      f.last_frame = is_last;
      return f;
   endfunction

   task automatic queue_frame(input req_payload_type f);
      frame_queue = {frame_queue, f};
   endtask

   task automatic queue_track(input int len);
      for (int i = 0; i < len; i++) queue_frame(rand_frame(i == len - 1));
   endtask

   // Wait until every queued frame is sent and every result has arrived.
   task automatic drain();
      while (frame_queue.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (FLUSH_WAIT) @(posedge clock);
   endtask

   task automatic write_scale(input logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scale_reg = v;
   endtask

   // Driver: offers queued frames, idling at random between transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_frame(req_payload);
            frames_sent++;
            if (req_payload.last_frame) tracks_sent++;
         end
         if (frame_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= frame_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $realtime,
                        rsp_payload);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== rsp_payload) begin
                  $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r,
                           rsp_payload);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Run limit.
   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      errors = 0; frames_sent = 0; results_seen = 0; tracks_sent = 0;
      stimulus_done = 0; hold_cycles = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      req_valid = 1'b0; req_payload = '0; csr_wr_en = 1'b0; csr_wr_data = '0;
      rsp_ready = 1'b0;
      for (int i = 0; i < WIN; i++)
         for (int k = 0; k < COMP_N; k++) begin
            quat_hist[i][k] = 0; rate_hist[i][k] = 0;
         end
      track_frames = 0; next_emit = 0; scale_reg = RATE_OVER_TWELVE_RESET;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-frame track, extremes, orthogonal and opposite frames.
      send_idle_pct = 38; recv_idle_pct = 54;
      queue_frame(mk_frame(16384, 0, 0, 0, 1));
      queue_frame(mk_frame(32767, 32767, 32767, 32767, 0));
      queue_frame(mk_frame(-32768, -32768, -32768, -32768, 0));
      queue_frame(mk_frame(0, 16384, 0, 0, 0));
      queue_frame(mk_frame(16384, 0, 0, 0, 0));
      queue_frame(mk_frame(-16384, 0, 0, 0, 0));
      queue_frame(mk_frame(32767, -32768, 32767, -32768, 0));
      queue_frame(mk_frame(0, 0, 0, 16384, 1));
      queue_frame(mk_frame(11585, 11585, 0, 0, 0));
      queue_frame(mk_frame(11585, 0, 11585, 0, 1));
      queue_frame(mk_frame(0, 0, -32768, 0, 0));
      queue_frame(mk_frame(16384, 100, -100, 50, 0));
      queue_frame(mk_frame(-16384, -200, 300, 0, 1));
      drain();

      // Scale extremes on short tracks.
      write_scale(16'hFFFF);
      queue_track(6); queue_track(3);
      drain();
      write_scale(16'h0000);
      queue_track(5);
      drain();
      write_scale(16'h0001);
      queue_track(4); queue_track(2);
      drain();

      // Random tracks: back-pressure, then the reverse, then none.
      write_scale(RATE_OVER_TWELVE_RESET);
      repeat (20) queue_track($urandom_range(1, 14));
      hold_cycles = 2000;
      drain();
      write_scale(16'($urandom));
      send_idle_pct = 54; recv_idle_pct = 38;
      repeat (20) queue_track($urandom_range(1, 14));
      drain();
      write_scale(16'd3200);
      send_idle_pct = 0; recv_idle_pct = 0;
      while (frames_sent + frame_queue.size() < 460) queue_track($urandom_range(1, 16));
      drain();

      $display("Covered %0d frames in %0d tracks, %0d results checked.",
               frames_sent, tracks_sent, results_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
